// ===== hw/rtl/mfm_enc_pkg.sv =====
// shared types, constants and helpers of the mfm track encoder
// no dependencies
`default_nettype none

package mfm_enc_pkg;

    localparam int SECTOR_LONGWORDS = 128;
    localparam int SECTOR_WORDS     = 16 + 2 * SECTOR_LONGWORDS;
    localparam int STORE_AW         = $clog2(SECTOR_LONGWORDS);
    localparam int LOAD_W           = STORE_AW + 1;
    localparam int WIDX_W           = $clog2(SECTOR_WORDS);

    localparam logic [31:0] MASK_EVEN = 32'h5555_5555;
    localparam logic [31:0] MASK_CLK  = 32'hAAAA_AAAA;
    localparam logic [31:0] GAP_WORD  = 32'hAAAA_AAAA;
    localparam logic [31:0] LEAD_ONE  = 32'h2AAA_AAAA;
    localparam logic [31:0] SYNC_WORD = 32'h4489_4489;
    localparam logic [7:0]  INFO_FMT  = 8'hFF;

    localparam logic [1:0] CFG_TRACK   = 2'd0;
    localparam logic [1:0] CFG_SECTORS = 2'd1;
    localparam logic [1:0] CFG_GAP     = 2'd2;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    localparam logic ST_OK        = 1'b0;
    localparam logic ST_NOT_READY = 1'b1;

    typedef enum logic [1:0] {
        PH_GAP    = 2'd0,
        PH_SECTOR = 2'd1,
        PH_TRAIL  = 2'd2
    } t_phase;

    typedef enum logic {
        BS_IDLE = 1'b0,
        BS_EXEC = 1'b1
    } t_bstate;

    typedef struct packed {
        logic        action;
        logic [31:0] data_word;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qstat;

    typedef struct packed {
        logic [7:0]  track_number;
        logic [7:0]  sectors_in_track;
        logic [15:0] gap_longwords;
    } t_cfg;

    function automatic logic [31:0] add_clock(input logic [31:0] v, input logic prev_bit);
        logic [31:0] d;
        logic [31:0] left;
        logic [31:0] right;
        d     = v & MASK_EVEN;
        left  = {prev_bit, d[31:1]};
        right = {d[30:0], 1'b0};
        return d | (~left & ~right & MASK_CLK);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mfm_enc_in_if.sv =====
// input channel of the mfm track encoder: valid, ready and item payload
// no dependencies
`default_nettype none

interface mfm_enc_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] data_word;

    modport source(output valid, output action, output data_word, input ready);
    modport sink(input valid, input action, input data_word, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mfm_enc_out_if.sv =====
// output channel of the mfm track encoder: valid, ready and result payload
// no dependencies
`default_nettype none

interface mfm_enc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] word_out;
    logic        status;
    logic        last_of_track;

    modport source(output valid, output word_out, output status, output last_of_track,
                   input ready);
    modport sink(input valid, input word_out, input status, input last_of_track,
                 output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mfm_enc_front.sv =====
// front end: accepts items and holds them in a two-entry queue
// depends on mfm_enc_pkg, mfm_enc_in_if
`default_nettype none

module mfm_enc_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    mfm_enc_in_if.sink           i_in,
    input  wire                  i_pop,
    output mfm_enc_pkg::t_qstat  o_q
);

    mfm_enc_pkg::t_item r_q [2];
    logic               r_wptr;
    logic               r_rptr;
    logic [1:0]         r_cnt;
    logic               w_push;
    logic               w_pop;

    assign i_in.ready = (r_cnt != 2'd2);
    assign w_push     = i_in.valid && i_in.ready;
    assign w_pop      = i_pop && (r_cnt != 2'd0);

    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.item  = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr].action    <= i_in.action;
            r_q[r_wptr].data_word <= i_in.data_word;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mfm_enc_back.sv =====
// back end: sector store, track sequencing, mfm encoding and result register
// depends on mfm_enc_pkg, mfm_enc_out_if
`default_nettype none

module mfm_enc_back (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire mfm_enc_pkg::t_cfg    i_cfg,
    input  wire mfm_enc_pkg::t_qstat  i_q,
    output logic                      o_pop,
    mfm_enc_out_if.source             o_out
);

    localparam int AW = mfm_enc_pkg::STORE_AW;
    localparam int LW = mfm_enc_pkg::LOAD_W;
    localparam int XW = mfm_enc_pkg::WIDX_W;

    logic [31:0] r_mem [mfm_enc_pkg::SECTOR_LONGWORDS];

    mfm_enc_pkg::t_bstate r_state, n_state;
    mfm_enc_pkg::t_item   r_item;
    logic [31:0]          r_rd_data;

    mfm_enc_pkg::t_phase  r_phase, n_phase;
    logic [LW-1:0]        r_loaded, n_loaded;
    logic [31:0]          r_cks, n_cks;
    logic [15:0]          r_gap_cnt, n_gap_cnt;
    logic [XW-1:0]        r_widx, n_widx;
    logic [7:0]           r_sector, n_sector;
    logic                 r_prev_bit, n_prev_bit;
    logic                 r_lsb, n_lsb;

    logic                 r_out_valid;
    logic [31:0]          r_word, n_word;
    logic                 r_status, n_status;
    logic                 r_last, n_last;

    logic                 w_out_free;
    logic                 w_exec;
    logic                 w_mem_we;
    logic [AW-1:0]        w_rd_addr;
    logic [XW-1:0]        w_pop_widx;

    logic [31:0]          w_info;
    logic [31:0]          w_info_odd;
    logic [31:0]          w_info_even;
    logic [31:0]          w_hck;
    logic [31:0]          w_v;
    logic [XW-1:0]        w_w;
    logic [XW-1:0]        w_w1;
    logic [7:0]           w_sector1;
    logic                 w_gap_emit;
    logic                 w_ph_gap;

    assign w_out_free = !r_out_valid || o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mfm_enc_pkg::BS_IDLE: if (i_q.valid) n_state = mfm_enc_pkg::BS_EXEC;
            mfm_enc_pkg::BS_EXEC: if (w_out_free) n_state = mfm_enc_pkg::BS_IDLE;
            default:              n_state = mfm_enc_pkg::BS_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop  = 1'b0;
        w_exec = 1'b0;
        unique case (r_state)
            mfm_enc_pkg::BS_IDLE: o_pop  = i_q.valid;
            mfm_enc_pkg::BS_EXEC: w_exec = w_out_free;
            default: begin
                o_pop  = 1'b0;
                w_exec = 1'b0;
            end
        endcase
    end

    // store read address for the word about to be fetched
    assign w_pop_widx = (r_phase == mfm_enc_pkg::PH_SECTOR) ? r_widx : '0;
    assign w_rd_addr  = w_pop_widx[AW-1:0] - AW'(16);

    assign w_ph_gap   = (r_phase != mfm_enc_pkg::PH_SECTOR) &&
                        (r_phase != mfm_enc_pkg::PH_TRAIL);
    assign w_gap_emit = w_ph_gap && (i_cfg.gap_longwords > 16'd1) &&
                        (r_gap_cnt < (i_cfg.gap_longwords - 16'd1));

    assign w_info      = {mfm_enc_pkg::INFO_FMT, i_cfg.track_number, r_sector,
                          i_cfg.sectors_in_track - r_sector};
    assign w_info_odd  = (w_info >> 1) & mfm_enc_pkg::MASK_EVEN;
    assign w_info_even = w_info & mfm_enc_pkg::MASK_EVEN;
    assign w_hck       = w_info_odd ^ w_info_even;

    assign w_w       = (w_ph_gap || r_widx >= XW'(mfm_enc_pkg::SECTOR_WORDS)) ? '0 : r_widx;
    assign w_w1      = w_w + XW'(1);
    assign w_sector1 = r_sector + 8'd1;

    always_comb begin
        if (w_w == XW'(2))       w_v = w_info_odd;
        else if (w_w == XW'(3))  w_v = w_info_even;
        else if (w_w < XW'(12))  w_v = '0;
        else if (w_w == XW'(12)) w_v = (w_hck >> 1) & mfm_enc_pkg::MASK_EVEN;
        else if (w_w == XW'(13)) w_v = w_hck & mfm_enc_pkg::MASK_EVEN;
        else if (w_w == XW'(14)) w_v = (r_cks >> 1) & mfm_enc_pkg::MASK_EVEN;
        else if (w_w == XW'(15)) w_v = r_cks & mfm_enc_pkg::MASK_EVEN;
        else if (w_w < XW'(16 + mfm_enc_pkg::SECTOR_LONGWORDS))
            w_v = (r_rd_data >> 1) & mfm_enc_pkg::MASK_EVEN;
        else
            w_v = r_rd_data & mfm_enc_pkg::MASK_EVEN;
    end

    always_comb begin
        n_phase    = r_phase;
        n_loaded   = r_loaded;
        n_cks      = r_cks;
        n_gap_cnt  = r_gap_cnt;
        n_widx     = r_widx;
        n_sector   = r_sector;
        n_prev_bit = r_prev_bit;
        n_lsb      = r_lsb;
        n_word     = '0;
        n_status   = mfm_enc_pkg::ST_OK;
        n_last     = 1'b0;
        w_mem_we   = 1'b0;

        if (r_item.action == mfm_enc_pkg::ACT_LOAD) begin
            if (r_loaded[LW-1]) begin
                n_status = mfm_enc_pkg::ST_NOT_READY;
            end else begin
                w_mem_we = 1'b1;
                n_cks    = r_cks ^ ((r_item.data_word >> 1) & mfm_enc_pkg::MASK_EVEN)
                                 ^ (r_item.data_word & mfm_enc_pkg::MASK_EVEN);
                n_loaded = r_loaded + LW'(1);
            end
        end else if (w_gap_emit) begin
            n_gap_cnt = r_gap_cnt + 16'd1;
            n_lsb     = 1'b0;
            n_word    = mfm_enc_pkg::GAP_WORD;
        end else if (r_phase == mfm_enc_pkg::PH_TRAIL) begin
            n_word     = mfm_enc_pkg::add_clock('0, r_lsb);
            n_last     = 1'b1;
            n_phase    = mfm_enc_pkg::PH_GAP;
            n_gap_cnt  = '0;
            n_widx     = '0;
            n_sector   = '0;
            n_prev_bit = 1'b0;
            n_lsb      = 1'b0;
        end else if (!r_loaded[LW-1]) begin
            n_status = mfm_enc_pkg::ST_NOT_READY;
        end else begin
            if (w_w == XW'(0)) begin
                n_word = r_lsb ? mfm_enc_pkg::LEAD_ONE : mfm_enc_pkg::GAP_WORD;
            end else if (w_w == XW'(1)) begin
                n_word = mfm_enc_pkg::SYNC_WORD;
            end else begin
                n_word     = mfm_enc_pkg::add_clock(w_v, (w_w == XW'(2)) ? 1'b1 : r_prev_bit);
                n_prev_bit = w_v[0];
            end
            n_lsb   = n_word[0];
            n_phase = mfm_enc_pkg::PH_SECTOR;
            if (w_w1 >= XW'(mfm_enc_pkg::SECTOR_WORDS)) begin
                n_loaded = '0;
                n_cks    = '0;
                n_widx   = '0;
                n_sector = w_sector1;
                if (w_sector1 == i_cfg.sectors_in_track) begin
                    if (i_cfg.gap_longwords != 16'd0) begin
                        n_phase = mfm_enc_pkg::PH_TRAIL;
                    end else begin
                        n_last     = 1'b1;
                        n_phase    = mfm_enc_pkg::PH_GAP;
                        n_gap_cnt  = '0;
                        n_sector   = '0;
                        n_prev_bit = 1'b0;
                        n_lsb      = 1'b0;
                    end
                end
            end else begin
                n_widx = w_w1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mfm_enc_pkg::BS_IDLE;
            r_phase     <= mfm_enc_pkg::PH_GAP;
            r_loaded    <= '0;
            r_cks       <= '0;
            r_gap_cnt   <= '0;
            r_widx      <= '0;
            r_sector    <= '0;
            r_prev_bit  <= 1'b0;
            r_lsb       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_exec) begin
                r_phase     <= n_phase;
                r_loaded    <= n_loaded;
                r_cks       <= n_cks;
                r_gap_cnt   <= n_gap_cnt;
                r_widx      <= n_widx;
                r_sector    <= n_sector;
                r_prev_bit  <= n_prev_bit;
                r_lsb       <= n_lsb;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_q.item;
        end
        if (w_exec) begin
            r_word   <= n_word;
            r_status <= n_status;
            r_last   <= n_last;
        end
    end

    // sector store
    always_ff @(posedge i_clk) begin
        if (w_exec && w_mem_we) begin
            r_mem[r_loaded[AW-1:0]] <= r_item.data_word;
        end
        if (o_pop) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.word_out      = r_word;
    assign o_out.status        = r_status;
    assign o_out.last_of_track = r_last;

endmodule

`default_nettype wire

// ===== hw/rtl/mfm_track_encoder.sv =====
// top level of the mfm track encoder: config registers, front and back
// depends on mfm_enc_pkg, mfm_enc_in_if, mfm_enc_out_if, mfm_enc_front, mfm_enc_back
//
// usage:
//   i_in carries items: action load (data_word stored into the sector store)
//   or fetch (next encoded longword of the track). every item gives exactly one
//   result on o_out: word_out, status (not ready when loading into a full store
//   or fetching sector words before all 128 longwords are loaded) and
//   last_of_track on the final word of a track, after which a new track starts.
//   config is written through i_cfg_we / i_cfg_idx / i_cfg_data while idle:
//   index 0 track number, 1 sectors per track, 2 gap longwords.
// flow:
//   an accepted item enters a two-entry queue; the back end pops it, reads the
//   sector store (registered read) and then encodes it into the result register.
//   the back end handles one item at a time: it pops the next item only after
//   the last one has been executed, by the pop-then-execute sequence around the
//   sector store read port.
// reset:
//   config returns to track 0, 11 sectors, no gap; the store is empty and the
//   track restarts at its leading gap. store contents are not cleared.
// stall:
//   the result register holds until taken, the back end waits, the queue fills
//   and i_in.ready drops once both entries are occupied.
`default_nettype none

module mfm_track_encoder (
    input  wire               i_clk,
    input  wire               i_rst_n,
    mfm_enc_in_if.sink        i_in,
    mfm_enc_out_if.source     o_out,
    input  wire               i_cfg_we,
    input  wire [1:0]         i_cfg_idx,
    input  wire [15:0]        i_cfg_data
);

    mfm_enc_pkg::t_cfg   r_cfg;
    mfm_enc_pkg::t_qstat w_q;
    logic                w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.track_number     <= 8'd0;
            r_cfg.sectors_in_track <= 8'd11;
            r_cfg.gap_longwords    <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mfm_enc_pkg::CFG_TRACK:   r_cfg.track_number     <= i_cfg_data[7:0];
                mfm_enc_pkg::CFG_SECTORS: r_cfg.sectors_in_track <= i_cfg_data[7:0];
                mfm_enc_pkg::CFG_GAP:     r_cfg.gap_longwords    <= i_cfg_data;
                default:                  r_cfg                  <= r_cfg;
            endcase
        end
    end

    mfm_enc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (w_pop),
        .o_q     (w_q)
    );

    mfm_enc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_q     (w_q),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q.valid)
        else $error("back end popped an empty queue");

    a_full_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> w_q.valid)
        else $error("input stalled with an empty queue");

    a_pop_then_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !o_out.valid) |=> !w_pop)
        else $error("back end popped twice in a row");

    a_cfg_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == mfm_enc_pkg::CFG_GAP) |=>
        (r_cfg.gap_longwords == $past(i_cfg_data)))
        else $error("gap register write lost");

endmodule

`default_nettype wire

// ===== tb/mfm_track_encoder_tb.sv =====
// self-checking testbench of mfm_track_encoder: directed items, then random sector
// loads and track fetches checked against an in-bench track predictor
// depends on mfm_enc_pkg, mfm_enc_in_if, mfm_enc_out_if and the rtl of mfm_track_encoder

module mfm_track_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mfm_enc_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int ITEM_TARGET = 2000;

    typedef struct packed {
        logic [31:0] word;
        logic        status;
        logic        last;
    } t_track_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_data;

    mfm_enc_in_if  in_if();
    mfm_enc_out_if out_if();

    mfm_track_encoder DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_if),
        .o_out     (out_if),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    wire in_fire  = in_if.valid && in_if.ready;
    wire out_fire = out_if.valid && out_if.ready;

    // predictor state
    logic [7:0]  cfg_track;
    logic [7:0]  cfg_sectors;
    logic [15:0] cfg_gap;
    logic [31:0] store_image [SECTOR_LONGWORDS];
    int unsigned loaded_cnt;
    logic [31:0] data_csum;
    t_phase      trk_phase;
    logic [15:0] gap_cnt;
    int unsigned word_idx;
    logic [7:0]  sector_idx;
    logic [31:0] prev_bits;
    logic        last_lsb;

    t_item       pending_items[$];
    t_track_word expected_words[$];
    int          items_issued;
    int          results_checked;
    int          error_count;
    int          quiet_cycles;
    logic        in_taken;
    t_item       next_item;
    int          send_burst;
    int          send_idle;
    logic        hold_request;
    int          hold_left;
    logic [15:0] stall_pattern;
    int          pattern_age;
    t_track_word want;
    t_track_word got;

    function automatic logic [31:0] mfm_clocked(input logic [31:0] raw, input logic prev);
        logic [31:0] r;
        logic        upper;
        r = raw & MASK_EVEN;
        for (int i = 0; i < 16; i++) begin
            if (i == 15) begin
                upper = prev;
            end else begin
                upper = r[2*i+2];
            end
            r[2*i+1] = ~upper & ~r[2*i];
        end
        return r;
    endfunction

    function automatic void restart_track();
        trk_phase  = PH_GAP;
        gap_cnt    = '0;
        word_idx   = 0;
        sector_idx = '0;
        prev_bits  = '0;
        last_lsb   = 1'b0;
    endfunction

    function automatic t_track_word encode_step(input logic act, input logic [31:0] d);
        t_track_word r;
        t_phase      ph;
        int unsigned w;
        logic [31:0] info;
        logic [31:0] hck;
        logic [31:0] raw;
        logic [31:0] word;
        logic        prev;
        r = '0;
        if (act == ACT_LOAD) begin
            if (loaded_cnt >= SECTOR_LONGWORDS) begin
                r.status = ST_NOT_READY;
            end else begin
                store_image[loaded_cnt] = d;
                data_csum = data_csum ^ ((d >> 1) & MASK_EVEN) ^ (d & MASK_EVEN);
                loaded_cnt++;
            end
            return r;
        end
        ph = trk_phase;
        if (ph == PH_GAP) begin
            if (cfg_gap > 16'd1 && gap_cnt < cfg_gap - 16'd1) begin
                gap_cnt  = gap_cnt + 16'd1;
                last_lsb = 1'b0;
                r.word   = GAP_WORD;
                return r;
            end
            ph = PH_SECTOR;
            word_idx = 0;
        end
        if (ph == PH_TRAIL) begin
            r.word = mfm_clocked(32'h0, last_lsb);
            r.last = 1'b1;
            restart_track();
            return r;
        end
        if (loaded_cnt < SECTOR_LONGWORDS) begin
            r.status = ST_NOT_READY;
            return r;
        end
        w = (word_idx >= SECTOR_WORDS) ? 0 : word_idx;
        if (w == 0) begin
            word = last_lsb ? LEAD_ONE : GAP_WORD;
        end else if (w == 1) begin
            word = SYNC_WORD;
        end else begin
            info = {INFO_FMT, cfg_track, sector_idx, cfg_sectors - sector_idx};
            hck  = ((info >> 1) & MASK_EVEN) ^ (info & MASK_EVEN);
            if (w == 2) begin
                raw = (info >> 1) & MASK_EVEN;
            end else if (w == 3) begin
                raw = info & MASK_EVEN;
            end else if (w < 12) begin
                raw = '0;
            end else if (w == 12) begin
                raw = (hck >> 1) & MASK_EVEN;
            end else if (w == 13) begin
                raw = hck & MASK_EVEN;
            end else if (w == 14) begin
                raw = (data_csum >> 1) & MASK_EVEN;
            end else if (w == 15) begin
                raw = data_csum & MASK_EVEN;
            end else if (w < 16 + SECTOR_LONGWORDS) begin
                raw = (store_image[w - 16] >> 1) & MASK_EVEN;
            end else begin
                raw = store_image[w - 16 - SECTOR_LONGWORDS] & MASK_EVEN;
            end
            prev = (w == 2) ? 1'b1 : prev_bits[0];
            word = mfm_clocked(raw, prev);
            prev_bits = raw;
        end
        r.word    = word;
        last_lsb  = word[0];
        trk_phase = PH_SECTOR;
        w++;
        if (w >= SECTOR_WORDS) begin
            loaded_cnt = 0;
            data_csum  = '0;
            word_idx   = 0;
            sector_idx = sector_idx + 8'd1;
            if (sector_idx == cfg_sectors) begin
                if (cfg_gap >= 16'd1) begin
                    trk_phase = PH_TRAIL;
                end else begin
                    r.last = 1'b1;
                    restart_track();
                end
            end
        end else begin
            word_idx = w;
        end
        return r;
    endfunction

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_TRACK;
        cfg_data        = '0;
        in_if.valid     = 1'b0;
        in_if.action    = ACT_LOAD;
        in_if.data_word = '0;
        out_if.ready    = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver: bursts of items with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            in_taken = 1'b0;
            if (send_idle > 0) begin
                send_idle--;
                in_if.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                next_item = pending_items.pop_front();
                in_if.valid     <= 1'b1;
                in_if.action    <= next_item.action;
                in_if.data_word <= next_item.data_word;
                if (send_burst > 0) begin
                    send_burst--;
                end else begin
                    send_burst = $urandom_range(1, 40);
                    send_idle  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, with an occasional long hold
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            if (pattern_age == 0) begin
                stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
                pattern_age   = 48;
            end else begin
                stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
                pattern_age--;
            end
            out_if.ready <= stall_pattern[0];
        end
    end

    // monitor: predict accepted items, check results
    always @(posedge i_clk) begin
        if (i_rst_n && in_fire) begin
            expected_words.push_back(encode_step(in_if.action, in_if.data_word));
            in_taken = 1'b1;
        end
        if (i_rst_n && out_fire) begin
            results_checked++;
            got = {out_if.word_out, out_if.status, out_if.last_of_track};
            if (expected_words.size() == 0) begin
                if (error_count < 10) begin
                    $display("unexpected result: word %h status %0b last %0b",
                             got.word, got.status, got.last);
                end
                error_count++;
            end else begin
                want = expected_words.pop_front();
                if (want != got) begin
                    if (error_count < 10) begin
                        $display("mismatch on result %0d: expected %h/%0b/%0b, got %h/%0b/%0b",
                                 results_checked, want.word, want.status, want.last,
                                 got.word, got.status, got.last);
                    end
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || in_fire || out_fire) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic queue_item(input logic act, input logic [31:0] d);
        t_item it;
        while (pending_items.size() >= 16) @(posedge i_clk);
        it.action    = act;
        it.data_word = d;
        pending_items.push_back(it);
        items_issued++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (results_checked != items_issued);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_TRACK:   cfg_track   = val[7:0];
            CFG_SECTORS: cfg_sectors = val[7:0];
            CFG_GAP:     cfg_gap     = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    initial begin
        int          round;
        int          pick;
        logic [31:0] dword;
        items_issued    = 0;
        results_checked = 0;
        error_count     = 0;
        quiet_cycles    = 0;
        in_taken        = 1'b0;
        send_burst      = 0;
        send_idle       = 0;
        hold_request    = 1'b0;
        hold_left       = 0;
        stall_pattern   = 16'hFFFF;
        pattern_age     = 0;
        cfg_track       = 8'd0;
        cfg_sectors     = 8'd11;
        cfg_gap         = 16'd0;
        loaded_cnt      = 0;
        data_csum       = '0;
        restart_track();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fetch before any load, extreme data patterns
        queue_item(ACT_FETCH, 32'hFFFF_FFFF);
        queue_item(ACT_LOAD, 32'h0000_0000);
        queue_item(ACT_LOAD, 32'hFFFF_FFFF);
        queue_item(ACT_LOAD, 32'h5555_5555);
        queue_item(ACT_LOAD, 32'hAAAA_AAAA);
        queue_item(ACT_LOAD, 32'h8000_0000);
        queue_item(ACT_LOAD, 32'h0000_0001);
        queue_item(ACT_FETCH, 32'h0);
        wait_drained();

        // widest gap, then shortened mid leading gap
        write_reg(CFG_TRACK, 16'd255);
        write_reg(CFG_GAP, 16'hFFFF);
        repeat (20) queue_item(ACT_FETCH, $urandom());
        wait_drained();
        write_reg(CFG_GAP, 16'd1);
        write_reg(CFG_SECTORS, 16'd1);

        // one-sector track with trailing word, store full, receiver hold-off
        repeat (SECTOR_LONGWORDS - 6) queue_item(ACT_LOAD, $urandom());
        repeat (3) queue_item(ACT_LOAD, $urandom());
        hold_request = 1'b1;
        repeat (SECTOR_WORDS + 2) queue_item(ACT_FETCH, $urandom());

        round = 0;
        while (items_issued < ITEM_TARGET) begin
            round++;
            wait_drained();
            write_reg(CFG_TRACK, (round == 1) ? 16'd0 : 16'($urandom_range(0, 255)));
            pick = sector_idx + $urandom_range(1, 3);
            if (round == 2 || pick > 255) begin
                pick = 255;
            end
            write_reg(CFG_SECTORS, 16'(pick));
            write_reg(CFG_GAP, (round == 1) ? 16'd0 : 16'($urandom_range(0, 3)));

            repeat ($urandom_range(0, 12)) queue_item(1'($urandom_range(0, 1)), $urandom());
            for (int k = 0; k < SECTOR_LONGWORDS; k++) begin
                if ($urandom_range(0, 15) == 0) begin
                    queue_item(ACT_FETCH, $urandom());
                end
                dword = $urandom();
                if ($urandom_range(0, 7) == 0) begin
                    dword = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
                end
                queue_item(ACT_LOAD, dword);
            end
            repeat ($urandom_range(0, 3)) queue_item(ACT_LOAD, $urandom());
            repeat (SECTOR_WORDS + $urandom_range(0, 4)) queue_item(ACT_FETCH, $urandom());
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mfm_enc_pkg.sv
hw/rtl/mfm_enc_in_if.sv
hw/rtl/mfm_enc_out_if.sv
hw/rtl/mfm_enc_front.sv
hw/rtl/mfm_enc_back.sv
hw/rtl/mfm_track_encoder.sv
tb/mfm_track_encoder_tb.sv
